@@ sv/mcc_pkg.sv @@
`default_nettype none
package mcc_pkg;

   // request codes
   localparam logic [1:0] FUNC_MARKER = 2'd0;
   localparam logic [1:0] FUNC_SUN    = 2'd1;
   localparam logic [1:0] FUNC_END    = 2'd2;

   // register map (index taken from paddr[2])
   localparam logic REG_MERGE = 1'b0;
   localparam logic REG_SUN   = 1'b1;

   localparam logic [5:0] MERGE_RESET = 6'd5;
   localparam logic [7:0] SUN_RESET   = 8'd25;

   // results per frame
   localparam int RES_LIMIT = 64;
   localparam int RES_CNT_W = 7;

   localparam int COORD_W = 12;

   typedef struct packed {
      logic [1:0]         func;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] centroid_x;
      logic [COORD_W-1:0] centroid_y;
      logic               last;
      logic               none_found;
      logic               overflow;
   } rsp_type;

endpackage
`default_nettype wire

@@ sv/mcc_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module mcc_div #(
   parameter int SUM_W = 18,
   parameter int CNT_W = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic      [SUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  dsr_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W:0]    rem_sh;
   logic              fits;
   logic [CNT_W:0]    rem_nx;
   logic [CNT_W-1:0]  rem_in;

   // trial subtract
   always_comb begin
      rem_sh = {rem_ff, quo_ff[SUM_W-1]};
      fits   = rem_sh >= {1'b0, dsr_ff};
      rem_nx = fits ? rem_sh - {1'b0, dsr_ff} : rem_sh;
      rem_in = rem_nx[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
            step_ff <= STEP_W'(SUM_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff  <= {quo_ff[SUM_W-2:0], fits};
            rem_ff  <= rem_in;
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

@@ sv/marker_centroid_cluster.sv @@
`default_nettype none
// Channel | Direction | Handshake          | Beat
// req     | in        | req_valid/stall    | mcc_pkg::req_type (func, x, y)
// rsp     | out       | rsp_valid/stall    | mcc_pkg::rsp_type (centroid, flags)
// cfg     | in        | APB psel/penable   | merge_distance @0, sun_distance @4
//
// A marker or sun point is stored without stalling. An end-of-frame beat holds req_stall
// high for the whole frame pass: insertion sort, clustering (each marker against every
// cluster mean, computed by the serial dividers), then per cluster a division and a
// check against the sun points.
// Reset is synchronous and clears counts and config; stores need no clearing.
// A stalled rsp beat holds; the sequencer waits on it when emitting.
module marker_centroid_cluster #(
   parameter int MAX_MARKERS    = 64,
   parameter int MAX_SUN_POINTS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mcc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mcc_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [2:0]       paddr,
   input  wire logic [31:0]      pwdata,
   output logic      [31:0]      prdata,
   output logic                  pready
);

   localparam int CW     = mcc_pkg::COORD_W;
   localparam int MK_AW  = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
   localparam int MKC_W  = $clog2(MAX_MARKERS + 1);
   localparam int SN_AW  = (MAX_SUN_POINTS > 1) ? $clog2(MAX_SUN_POINTS) : 1;
   localparam int SNC_W  = $clog2(MAX_SUN_POINTS + 1);
   localparam int SUM_W  = CW + MKC_W;
   localparam int RCW    = mcc_pkg::RES_CNT_W;

   typedef struct packed {
      logic [SUM_W-1:0] sum_x;
      logic [SUM_W-1:0] sum_y;
      logic [MKC_W-1:0] members;
   } cl_entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_WAIT, S_SORT_NEXT, S_SORT_V, S_SORT_CMP, S_SORT_PUT,
      S_CL_NEXT, S_CL_P, S_CL_CD, S_CL_DIV, S_CL_DX, S_CL_MUL, S_CL_CMP,
      S_CL_UPD, S_CL_ADD, S_OUT_NEXT, S_OUT_CD, S_OUT_DIV, S_SUN_D,
      S_SUN_MUL, S_SUN_CMP, S_KEEP, S_FIN
   } state_type;

   state_type state_ff, ret_ff;

   // configuration
   logic [5:0]  merge_ff;
   logic [7:0]  sun_ff;
   logic [11:0] merge_sq_ff;
   logic [15:0] sun_sq_ff;

   // memories and their ports
   logic [2*CW-1:0]  mk_mem [MAX_MARKERS];
   logic [2*CW-1:0]  sn_mem [MAX_SUN_POINTS];
   cl_entry_type     cl_mem [MAX_MARKERS];
   logic             mk_we_ff, sn_we_ff, cl_we_ff;
   logic [MK_AW-1:0] mk_wa_ff, mk_ra_ff, cl_wa_ff, cl_ra_ff;
   logic [SN_AW-1:0] sn_wa_ff, sn_ra_ff;
   logic [2*CW-1:0]  mk_wd_ff, sn_wd_ff, mk_rd_ff, sn_rd_ff;
   cl_entry_type     cl_wd_ff, cl_rd_ff;

   // frame state
   logic [MKC_W-1:0] mk_cnt_ff, cl_cnt_ff, i_ff, j_ff, best_ff, oi_ff;
   logic [SNC_W-1:0] sn_cnt_ff, k_ff;
   logic             drop_ff;
   logic [2*CW-1:0]  v_ff, p_ff;
   logic [11:0]      best_d_ff;
   logic             found_ff;
   logic [RCW-1:0]   kept_ff;
   logic [CW-1:0]    cent_x_ff, cent_y_ff, pend_x_ff, pend_y_ff;
   logic             pend_v_ff;

   // distance datapath
   logic [CW-1:0]    dx_ff, dy_ff;
   logic [2*CW-1:0]  dxsq_ff, dysq_ff;
   logic [2*CW:0]    sq_sum;

   // divider
   logic             div_go_ff, div_done, div_done_y;
   logic [SUM_W-1:0] qx, qy;

   // output register
   logic             rsp_valid_ff;
   mcc_pkg::rsp_type rsp_data_ff;
   logic             out_free;
   logic             req_acc;
   logic             cfg_wr;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sq_sum    = {1'b0, dxsq_ff} + {1'b0, dysq_ff};
   assign cfg_wr    = psel && penable && pwrite;

   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
      abs_diff = (a > b) ? a - b : b - a;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         merge_ff <= mcc_pkg::MERGE_RESET;
         sun_ff   <= mcc_pkg::SUN_RESET;
      end else if (cfg_wr) begin
         if (paddr[2] == mcc_pkg::REG_MERGE) merge_ff <= pwdata[5:0];
         else                                sun_ff   <= pwdata[7:0];
      end
      merge_sq_ff <= 12'(merge_ff) * 12'(merge_ff);
      sun_sq_ff   <= 16'(sun_ff) * 16'(sun_ff);
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == mcc_pkg::REG_MERGE) ? 32'(merge_ff) : 32'(sun_ff);

   // memories
   always_ff @(posedge clock) begin
      if (mk_we_ff) mk_mem[mk_wa_ff] <= mk_wd_ff;
      mk_rd_ff <= mk_mem[mk_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (sn_we_ff) sn_mem[sn_wa_ff] <= sn_wd_ff;
      sn_rd_ff <= sn_mem[sn_ra_ff];
   end

   always_ff @(posedge clock) begin
      if (cl_we_ff) cl_mem[cl_wa_ff] <= cl_wd_ff;
      cl_rd_ff <= cl_mem[cl_ra_ff];
   end

   // mean dividers
   mcc_div #(.SUM_W(SUM_W), .CNT_W(MKC_W)) u_div_x (
      .clock, .reset, .start(div_go_ff), .dividend(cl_rd_ff.sum_x),
      .divisor(cl_rd_ff.members), .done(div_done), .quotient(qx)
   );

   mcc_div #(.SUM_W(SUM_W), .CNT_W(MKC_W)) u_div_y (
      .clock, .reset, .start(div_go_ff), .dividend(cl_rd_ff.sum_y),
      .divisor(cl_rd_ff.members), .done(div_done_y), .quotient(qy)
   );

   // frame sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         mk_we_ff     <= 1'b0;
         sn_we_ff     <= 1'b0;
         cl_we_ff     <= 1'b0;
         div_go_ff    <= 1'b0;
         mk_cnt_ff    <= '0;
         sn_cnt_ff    <= '0;
         cl_cnt_ff    <= '0;
         drop_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mk_we_ff  <= 1'b0;
         sn_we_ff  <= 1'b0;
         cl_we_ff  <= 1'b0;
         div_go_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  case (req_data.func)
                     mcc_pkg::FUNC_MARKER: begin
                        if (mk_cnt_ff < MKC_W'(MAX_MARKERS)) begin
                           mk_we_ff  <= 1'b1;
                           mk_wa_ff  <= mk_cnt_ff[MK_AW-1:0];
                           mk_wd_ff  <= {req_data.y, req_data.x};
                           mk_cnt_ff <= mk_cnt_ff + MKC_W'(1);
                        end else begin
                           drop_ff <= 1'b1;
                        end
                     end
                     mcc_pkg::FUNC_SUN: begin
                        if (sn_cnt_ff < SNC_W'(MAX_SUN_POINTS)) begin
                           sn_we_ff  <= 1'b1;
                           sn_wa_ff  <= sn_cnt_ff[SN_AW-1:0];
                           sn_wd_ff  <= {req_data.y, req_data.x};
                           sn_cnt_ff <= sn_cnt_ff + SNC_W'(1);
                        end else begin
                           drop_ff <= 1'b1;
                        end
                     end
                     mcc_pkg::FUNC_END: begin
                        i_ff     <= MKC_W'(1);
                        state_ff <= S_SORT_NEXT;
                     end
                     default: ;
                  endcase
               end
            end

            // wait state for the registered read address
            S_WAIT: state_ff <= ret_ff;

            // insertion sort on the marker store
            S_SORT_NEXT: begin
               if (i_ff < mk_cnt_ff) begin
                  mk_ra_ff <= i_ff[MK_AW-1:0];
                  ret_ff   <= S_SORT_V;
                  state_ff <= S_WAIT;
               end else begin
                  i_ff      <= '0;
                  cl_cnt_ff <= '0;
                  state_ff  <= S_CL_NEXT;
               end
            end
            S_SORT_V: begin
               v_ff     <= mk_rd_ff;
               j_ff     <= i_ff;
               mk_ra_ff <= MK_AW'(i_ff - MKC_W'(1));
               ret_ff   <= S_SORT_CMP;
               state_ff <= S_WAIT;
            end
            S_SORT_CMP: begin
               if (mk_rd_ff > v_ff) begin
                  mk_we_ff <= 1'b1;
                  mk_wa_ff <= j_ff[MK_AW-1:0];
                  mk_wd_ff <= mk_rd_ff;
                  j_ff     <= j_ff - MKC_W'(1);
                  if (j_ff > MKC_W'(1)) begin
                     mk_ra_ff <= MK_AW'(j_ff - MKC_W'(2));
                     ret_ff   <= S_SORT_CMP;
                     state_ff <= S_WAIT;
                  end else begin
                     state_ff <= S_SORT_PUT;
                  end
               end else begin
                  state_ff <= S_SORT_PUT;
               end
            end
            S_SORT_PUT: begin
               mk_we_ff <= 1'b1;
               mk_wa_ff <= j_ff[MK_AW-1:0];
               mk_wd_ff <= v_ff;
               i_ff     <= i_ff + MKC_W'(1);
               state_ff <= S_SORT_NEXT;
            end

            // clustering: scan every cluster mean for each sorted marker
            S_CL_NEXT: begin
               if (i_ff < mk_cnt_ff) begin
                  mk_ra_ff <= i_ff[MK_AW-1:0];
                  ret_ff   <= S_CL_P;
                  state_ff <= S_WAIT;
               end else begin
                  oi_ff     <= '0;
                  kept_ff   <= '0;
                  pend_v_ff <= 1'b0;
                  state_ff  <= S_OUT_NEXT;
               end
            end
            S_CL_P: begin
               p_ff      <= mk_rd_ff;
               j_ff      <= '0;
               best_d_ff <= merge_sq_ff;
               found_ff  <= 1'b0;
               if (cl_cnt_ff == '0) begin
                  state_ff <= S_CL_UPD;
               end else begin
                  cl_ra_ff <= '0;
                  ret_ff   <= S_CL_CD;
                  state_ff <= S_WAIT;
               end
            end
            S_CL_CD: begin
               div_go_ff <= 1'b1;
               state_ff  <= S_CL_DIV;
            end
            S_CL_DIV: if (div_done) state_ff <= S_CL_DX;
            S_CL_DX: begin
               dx_ff    <= abs_diff(qx[CW-1:0], p_ff[CW-1:0]);
               dy_ff    <= abs_diff(qy[CW-1:0], p_ff[2*CW-1:CW]);
               state_ff <= S_CL_MUL;
            end
            S_CL_MUL: begin
               dxsq_ff  <= (2*CW)'(dx_ff) * (2*CW)'(dx_ff);
               dysq_ff  <= (2*CW)'(dy_ff) * (2*CW)'(dy_ff);
               state_ff <= S_CL_CMP;
            end
            S_CL_CMP: begin
               if (sq_sum < (2*CW+1)'(best_d_ff)) begin
                  best_d_ff <= sq_sum[11:0];
                  best_ff   <= j_ff;
                  found_ff  <= 1'b1;
               end
               if (j_ff + MKC_W'(1) < cl_cnt_ff) begin
                  j_ff     <= j_ff + MKC_W'(1);
                  cl_ra_ff <= MK_AW'(j_ff + MKC_W'(1));
                  ret_ff   <= S_CL_CD;
                  state_ff <= S_WAIT;
               end else begin
                  state_ff <= S_CL_UPD;
               end
            end
            S_CL_UPD: begin
               if (found_ff) begin
                  cl_ra_ff <= best_ff[MK_AW-1:0];
                  ret_ff   <= S_CL_ADD;
                  state_ff <= S_WAIT;
               end else begin
                  if (cl_cnt_ff < MKC_W'(MAX_MARKERS)) begin
                     cl_we_ff         <= 1'b1;
                     cl_wa_ff         <= cl_cnt_ff[MK_AW-1:0];
                     cl_wd_ff.sum_x   <= SUM_W'(p_ff[CW-1:0]);
                     cl_wd_ff.sum_y   <= SUM_W'(p_ff[2*CW-1:CW]);
                     cl_wd_ff.members <= MKC_W'(1);
                     cl_cnt_ff        <= cl_cnt_ff + MKC_W'(1);
                  end
                  i_ff     <= i_ff + MKC_W'(1);
                  state_ff <= S_CL_NEXT;
               end
            end
            S_CL_ADD: begin
               cl_we_ff         <= 1'b1;
               cl_wa_ff         <= best_ff[MK_AW-1:0];
               cl_wd_ff.sum_x   <= cl_rd_ff.sum_x + SUM_W'(p_ff[CW-1:0]);
               cl_wd_ff.sum_y   <= cl_rd_ff.sum_y + SUM_W'(p_ff[2*CW-1:CW]);
               cl_wd_ff.members <= cl_rd_ff.members + MKC_W'(1);
               i_ff             <= i_ff + MKC_W'(1);
               state_ff         <= S_CL_NEXT;
            end

            // centroids, each checked against the sun points until one lies near
            S_OUT_NEXT: begin
               if (oi_ff < cl_cnt_ff && kept_ff < RCW'(mcc_pkg::RES_LIMIT)) begin
                  cl_ra_ff <= oi_ff[MK_AW-1:0];
                  ret_ff   <= S_OUT_CD;
                  state_ff <= S_WAIT;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_OUT_CD: begin
               div_go_ff <= 1'b1;
               state_ff  <= S_OUT_DIV;
            end
            S_OUT_DIV: begin
               if (div_done) begin
                  cent_x_ff <= qx[CW-1:0];
                  cent_y_ff <= qy[CW-1:0];
                  k_ff      <= '0;
                  if (sn_cnt_ff == '0) begin
                     state_ff <= S_KEEP;
                  end else begin
                     sn_ra_ff <= '0;
                     ret_ff   <= S_SUN_D;
                     state_ff <= S_WAIT;
                  end
               end
            end
            S_SUN_D: begin
               dx_ff    <= abs_diff(cent_x_ff, sn_rd_ff[CW-1:0]);
               dy_ff    <= abs_diff(cent_y_ff, sn_rd_ff[2*CW-1:CW]);
               state_ff <= S_SUN_MUL;
            end
            S_SUN_MUL: begin
               dxsq_ff  <= (2*CW)'(dx_ff) * (2*CW)'(dx_ff);
               dysq_ff  <= (2*CW)'(dy_ff) * (2*CW)'(dy_ff);
               state_ff <= S_SUN_CMP;
            end
            S_SUN_CMP: begin
               if (sq_sum < (2*CW+1)'(sun_sq_ff)) begin
                  oi_ff    <= oi_ff + MKC_W'(1);
                  state_ff <= S_OUT_NEXT;
               end else if (k_ff + SNC_W'(1) < sn_cnt_ff) begin
                  k_ff     <= k_ff + SNC_W'(1);
                  sn_ra_ff <= SN_AW'(k_ff + SNC_W'(1));
                  ret_ff   <= S_SUN_D;
                  state_ff <= S_WAIT;
               end else begin
                  state_ff <= S_KEEP;
               end
            end

            // hold one kept centroid back so the final one can carry last
            S_KEEP: begin
               if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     rsp_valid_ff            <= 1'b1;
                     rsp_data_ff.centroid_x  <= pend_x_ff;
                     rsp_data_ff.centroid_y  <= pend_y_ff;
                     rsp_data_ff.last        <= 1'b0;
                     rsp_data_ff.none_found  <= 1'b0;
                     rsp_data_ff.overflow    <= drop_ff;
                  end
                  pend_x_ff <= cent_x_ff;
                  pend_y_ff <= cent_y_ff;
                  pend_v_ff <= 1'b1;
                  kept_ff   <= kept_ff + RCW'(1);
                  oi_ff     <= oi_ff + MKC_W'(1);
                  state_ff  <= S_OUT_NEXT;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.centroid_x <= pend_v_ff ? pend_x_ff : '0;
                  rsp_data_ff.centroid_y <= pend_v_ff ? pend_y_ff : '0;
                  rsp_data_ff.last       <= 1'b1;
                  rsp_data_ff.none_found <= !pend_v_ff;
                  rsp_data_ff.overflow   <= drop_ff;
                  mk_cnt_ff              <= '0;
                  sn_cnt_ff              <= '0;
                  cl_cnt_ff              <= '0;
                  drop_ff                <= 1'b0;
                  pend_v_ff              <= 1'b0;
                  state_ff               <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_mk_cnt: assert property (@(posedge clock) disable iff (reset)
      mk_cnt_ff <= MKC_W'(MAX_MARKERS))
      else $error("marker count beyond store");

   a_cl_cnt: assert property (@(posedge clock) disable iff (reset)
      cl_cnt_ff <= mk_cnt_ff)
      else $error("more clusters than markers");

   a_kept: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= RCW'(mcc_pkg::RES_LIMIT))
      else $error("result limit exceeded");

   a_end_stall: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_data.func == mcc_pkg::FUNC_END) |=> req_stall)
      else $error("end of frame did not start the frame pass");

   a_div_sync: assert property (@(posedge clock) disable iff (reset)
      div_done == div_done_y)
      else $error("mean dividers out of step");

endmodule
`default_nettype wire

@@ sim/marker_centroid_cluster_tb.sv @@
`default_nettype none
module marker_centroid_cluster_tb;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 3000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mcc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mcc_pkg::rsp_type rsp_data;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [2:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;

   marker_centroid_cluster dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   logic [5:0]       merge_r = mcc_pkg::MERGE_RESET;
   logic [7:0]       sun_r   = mcc_pkg::SUN_RESET;
   logic [23:0]      markers[$];
   logic [23:0]      suns[$];
   bit               dropped = 1'b0;
   mcc_pkg::rsp_type centroid_q[$];

   int unsigned cycles = 0;
   int unsigned mismatches = 0;
   int unsigned frames = 0;
   int unsigned results = 0;
   int unsigned hold_left = 0;
   int unsigned hold_req = 0;
   int unsigned hold_seen = 0;
   bit          busy_mode = 1'b0;   // no idling on either side

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver stalls: random, or a long hold counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= !busy_mode && ($urandom_range(99) < 24);
      end
   end

   // result checker
   always @(posedge clock) begin
      mcc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results++;
         if (centroid_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat %p", rsp_data);
         end else begin
            want = centroid_q.pop_front();
            if (want.none_found ? (rsp_data.none_found !== 1'b1 ||
                                   rsp_data.last !== want.last ||
                                   rsp_data.overflow !== want.overflow ||
                                   rsp_data.centroid_x !== want.centroid_x ||
                                   rsp_data.centroid_y !== want.centroid_y)
                                : (rsp_data !== want)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   function automatic int unsigned sq_distance(int unsigned ax, int unsigned ay,
                                               int unsigned bx, int unsigned by);
      int unsigned dx, dy;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      return dx * dx + dy * dy;
   endfunction

   // end of frame: sort, cluster, drop centroids near the sun, queue results
   function automatic void predict_centroids();
      int unsigned sum_x[$], sum_y[$], members[$];
      int unsigned lim, best_d, best, d, px, py, cx, cy, n, sl;
      bit          found, near;
      mcc_pkg::rsp_type r;
      markers.sort();
      lim = merge_r * merge_r;
      foreach (markers[i]) begin
         px = markers[i][11:0];
         py = markers[i][23:12];
         best_d = lim;
         best = 0;
         found = 1'b0;
         foreach (sum_x[j]) begin
            d = sq_distance(sum_x[j] / members[j], sum_y[j] / members[j], px, py);
            if (d < best_d) begin
               best_d = d;
               best = j;
               found = 1'b1;
            end
         end
         if (found) begin
            sum_x[best] += px;
            sum_y[best] += py;
            members[best] += 1;
         end else begin
            sum_x.insert(sum_x.size(), px);
            sum_y.insert(sum_y.size(), py);
            members.insert(members.size(), 1);
         end
      end
      n = 0;
      sl = sun_r * sun_r;
      foreach (sum_x[i]) begin
         if (n < mcc_pkg::RES_LIMIT) begin
            cx = sum_x[i] / members[i];
            cy = sum_y[i] / members[i];
            near = 1'b0;
            foreach (suns[k])
               if (sq_distance(cx, cy, suns[k][11:0], suns[k][23:12]) < sl)
                  near = 1'b1;
            if (!near) begin
               r = '0;
               r.centroid_x = cx;
               r.centroid_y = cy;
               r.overflow = dropped;
               centroid_q.insert(centroid_q.size(), r);
               n++;
            end
         end
      end
      if (n == 0) begin
         r = '0;
         r.last = 1'b1;
         r.none_found = 1'b1;
         r.overflow = dropped;
         centroid_q.insert(centroid_q.size(), r);
      end else begin
         centroid_q[centroid_q.size() - 1].last = 1'b1;
      end
      markers.delete();
      suns.delete();
      dropped = 1'b0;
      frames++;
   endfunction

   function automatic void predict_beat(mcc_pkg::req_type b);
      case (b.func)
         mcc_pkg::FUNC_MARKER: if (markers.size() < 64)
                                  markers.insert(markers.size(), {b.y, b.x});
                               else dropped = 1'b1;
         mcc_pkg::FUNC_SUN:    if (suns.size() < 1024)
                                  suns.insert(suns.size(), {b.y, b.x});
                               else dropped = 1'b1;
         mcc_pkg::FUNC_END:    predict_centroids();
         default:              ;
      endcase
   endfunction

   // one beat; called just after a rising edge
   task automatic send_beat(logic [1:0] f, logic [11:0] px, logic [11:0] py);
      mcc_pkg::req_type b;
      if (!busy_mode && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 24) @(posedge clock);
      end
      b.func = f;
      b.x = px;
      b.y = py;
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_stall);
      predict_beat(b);
   endtask

   task automatic end_frame();
      send_beat(mcc_pkg::FUNC_END, 12'($urandom), 12'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (centroid_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [7:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == mcc_pkg::REG_MERGE) merge_r = value[5:0];
      else sun_r = value;
      @(posedge clock);
   endtask

   // markers scattered round a few centres, with a few sun points
   task automatic random_frame(int max_markers);
      int unsigned ncent, cxs[4], cys[4], c, off;
      ncent = $urandom_range(1, 4);
      for (int i = 0; i < ncent; i++) begin
         cxs[i] = $urandom_range(4095);
         cys[i] = $urandom_range(4095);
      end
      off = merge_r + 2;
      for (int i = $urandom_range(max_markers); i > 0; i--) begin
         c = $urandom_range(ncent - 1);
         if ($urandom_range(9) == 0)
            send_beat(2'd3, 12'($urandom), 12'($urandom));
         send_beat(mcc_pkg::FUNC_MARKER,
                   12'(cxs[c] + $urandom_range(off)),
                   12'(cys[c] + $urandom_range(off)));
      end
      for (int i = $urandom_range(2); i > 0; i--) begin
         c = $urandom_range(ncent - 1);
         if ($urandom_range(1))
            send_beat(mcc_pkg::FUNC_SUN, 12'(cxs[c]), 12'(cys[c]));
         else
            send_beat(mcc_pkg::FUNC_SUN, 12'($urandom), 12'($urandom));
      end
      end_frame();
   endtask

   task automatic test_defaults();
      send_beat(mcc_pkg::FUNC_MARKER, 12'd100, 12'd100);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd102, 12'd101);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd400, 12'd50);
      send_beat(mcc_pkg::FUNC_SUN, 12'd410, 12'd60);
      end_frame();
      end_frame();   // empty frame
      drain();
   endtask

   task automatic test_extremes();
      csr_write(mcc_pkg::REG_MERGE, 8'd63);
      csr_write(mcc_pkg::REG_SUN, 8'd0);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd0, 12'd0);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd4095, 12'd4095);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd4095, 12'd0);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd0, 12'd4095);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd40, 12'd40);
      send_beat(2'd3, 12'd4095, 12'd4095);
      send_beat(mcc_pkg::FUNC_SUN, 12'd0, 12'd0);
      end_frame();
      drain();
      // with no merge radius even identical points stay apart
      csr_write(mcc_pkg::REG_MERGE, 8'd0);
      csr_write(mcc_pkg::REG_SUN, 8'd255);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd2000, 12'd2000);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd2000, 12'd2000);
      send_beat(mcc_pkg::FUNC_SUN, 12'd1900, 12'd2100);
      end_frame();
      drain();
      csr_write(mcc_pkg::REG_MERGE, 8'd10);
      csr_write(mcc_pkg::REG_SUN, 8'd1);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd1000, 12'd1000);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd1010, 12'd1000);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd1005, 12'd1000);
      send_beat(mcc_pkg::FUNC_SUN, 12'd1005, 12'd1000);
      end_frame();
      drain();
   endtask

   task automatic test_marker_overflow();
      csr_write(mcc_pkg::REG_MERGE, 8'd0);
      csr_write(mcc_pkg::REG_SUN, 8'd0);
      busy_mode = 1'b1;
      for (int i = 0; i < 70; i++)
         send_beat(mcc_pkg::FUNC_MARKER, 12'($urandom), 12'($urandom));
      end_frame();
      drain();
      busy_mode = 1'b0;
   endtask

   task automatic test_sun_overflow();
      csr_write(mcc_pkg::REG_MERGE, 8'd5);
      csr_write(mcc_pkg::REG_SUN, 8'd3);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd50, 12'd60);
      send_beat(mcc_pkg::FUNC_MARKER, 12'd3000, 12'd3000);
      for (int i = 0; i < 1026; i++)
         send_beat(mcc_pkg::FUNC_SUN, 12'($urandom_range(100, 4095)), 12'($urandom));
      end_frame();
      drain();
   endtask

   // long receiver hold while frames keep coming
   task automatic test_backpressure();
      hold_req++;
      for (int i = 0; i < 4; i++)
         random_frame(6);
      drain();
   endtask

   task automatic test_random();
      int sent;
      sent = 0;
      while (sent < 220) begin
         case ($urandom_range(3))
            0: begin
               csr_write(mcc_pkg::REG_MERGE, 8'($urandom_range(63)));
               csr_write(mcc_pkg::REG_SUN, 8'($urandom_range(255)));
            end
            1: csr_write(mcc_pkg::REG_MERGE, 8'($urandom_range(1, 12)));
            default: ;
         endcase
         busy_mode = ($urandom_range(5) == 0);
         for (int f = 0; f < 4; f++) begin
            random_frame(10);
            sent += 8;
         end
         drain();
      end
      busy_mode = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_extremes();
      test_marker_overflow();
      test_sun_overflow();
      test_backpressure();
      test_random();
      drain();
      $display("%0d frames sent, %0d result beats checked, %0d mismatches",
               frames, results, mismatches);
      $display("covered register extremes, store overflow, sun masking and long hold");
      if (mismatches == 0 && centroid_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ marker_centroid_cluster.f @@
sv/mcc_pkg.sv
sv/mcc_div.sv
sv/marker_centroid_cluster.sv
sim/marker_centroid_cluster_tb.sv
